/* sv/w2h_pkg.sv */
// shared constants, types and state encoding of the weighted 2d histogram accumulator
// no dependencies; used by w2h_div and weighted_2d_histogram_accumulator
package w2h_pkg;

	// grid size, fixed at build time
	localparam int MAX_BINS_X = 64;
	localparam int MAX_BINS_Y = 64;
	localparam int STORE_DEPTH = MAX_BINS_X * MAX_BINS_Y;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// field widths
	localparam int BIN_W = 8;
	localparam int CFG_W = 7;
	localparam int CNT_W = 9;
	localparam int VAL_W = 32;
	localparam int WGT_W = 24;
	localparam int VSUM_W = 48;
	localparam int WSUM_W = 40;
	localparam int AVG_W = 32;
	localparam int STEP_W = $clog2(AVG_W + 1);

	// packed stream widths
	localparam int IN_DATA_W = 2 * BIN_W + VAL_W + WGT_W;
	localparam int OUT_DATA_W = VSUM_W + WSUM_W + AVG_W;
	localparam int OUT_USER_W = 2;

	// configuration register indexes
	localparam logic REG_BINS_X = 1'b0;
	localparam logic REG_BINS_Y = 1'b1;

	// saturation limits
	localparam logic [VSUM_W-1:0] VSUM_MAX = {1'b0, {(VSUM_W-1){1'b1}}};
	localparam logic [VSUM_W-1:0] VSUM_MIN = {1'b1, {(VSUM_W-1){1'b0}}};
	localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
	localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ADD,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} w2h_state_t;

	// divider result toward the sequencer
	typedef struct packed {
		logic done;
		logic [AVG_W-1:0] quot;
	} w2h_div_out_t;

endpackage

/* sv/w2h_div.sv */
// radix-2 restoring divider for the bin average: (|vsum| * 2^16) / wsum, signed, saturated
// depends on w2h_pkg
module w2h_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [w2h_pkg::VSUM_W-1:0] vsum,
	input  logic [w2h_pkg::WSUM_W-1:0] wsum,
	output w2h_pkg::w2h_div_out_t div_out
);
	import w2h_pkg::*;

	logic run_q;
	logic [STEP_W-1:0] cnt_q;
	logic neg_q;
	logic ovf_q;
	logic [WSUM_W-1:0] den_q;
	logic [WSUM_W-1:0] rem_q;
	logic [AVG_W-1:0] dq_q;
	logic [AVG_W-1:0] quot_q;

	logic [VSUM_W-1:0] mag;
	logic ovf;
	logic [WSUM_W:0] trial;
	logic [WSUM_W:0] diff;
	logic take;

	// magnitude and quotient overflow check, used in the start cycle
	always_comb begin
		mag = vsum[VSUM_W-1] ? (~vsum + 1'b1) : vsum;
		ovf = {{(WSUM_W + 16 - VSUM_W){1'b0}}, mag} >= {wsum, 16'b0};
	end

	// subtract unit: one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dq_q[AVG_W-1]};
		diff = trial - {1'b0, den_q};
		take = !diff[WSUM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= ovf ? '0 : STEP_W'(AVG_W);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= vsum[VSUM_W-1];
			ovf_q <= ovf;
			den_q <= wsum;
			rem_q <= WSUM_W'(mag[VSUM_W-1:16]);
			dq_q <= {mag[15:0], 16'b0};
			quot_q <= '0;
		end else if (run_q && cnt_q != '0) begin
			rem_q <= take ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
			dq_q <= {dq_q[AVG_W-2:0], 1'b0};
			quot_q <= {quot_q[AVG_W-2:0], take};
		end
	end

	// sign and saturation of the finished quotient
	always_comb begin
		div_out.done = run_q && cnt_q == '0;
		if (neg_q) begin
			div_out.quot = (ovf_q || quot_q > AVG_MIN) ? AVG_MIN : (~quot_q + 1'b1);
		end else begin
			div_out.quot = (ovf_q || quot_q[AVG_W-1]) ? AVG_MAX : quot_q;
		end
	end

endmodule

/* sv/weighted_2d_histogram_accumulator.sv */
// top level of the weighted 2d histogram accumulator: sequencer, bin store, output register
// depends on w2h_pkg and w2h_div
//
// usage:
//  - input stream s_*: one transfer per item, tdata holds bin_x, bin_y, add_value, add_weight
//  - output stream m_*: one transfer per item with the updated bin sums and the bin average
//  - config channel cfg_*: writes bins_in_use_x (index 0) or bins_in_use_y (index 1);
//    always ready, meant to be used while the block is idle
//  - an item with value 0 and weight 0 is a plain read of the bin
// sequence:
//  - in-range item with nonzero weight sum: read, add and write back the bin, then the 32-step
//    restoring divider; the divider skips its steps when the average saturates early
//  - out-of-range item: straight to the output; zero weight sum: no divider pass
//  - one item at a time: s_tready is high only while the sequencer idles
// reset:
//  - after arst_n releases, a clearing pass writes zero to all 4096 bins, one per cycle;
//    s_tready stays low during the pass, config writes are taken meanwhile
// stall:
//  - the result sits in an output register; the next item is accepted while it waits,
//    and that item's result is held back until m_tready frees the register
module weighted_2d_histogram_accumulator (
	input  logic clk,
	input  logic arst_n,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [w2h_pkg::IN_DATA_W-1:0] s_tdata,  // bin_x, bin_y, add_value, add_weight
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	output logic [w2h_pkg::OUT_DATA_W-1:0] m_tdata, // value_total, weight_total, average
	output logic [w2h_pkg::OUT_USER_W-1:0] m_tuser, // in_range, average_valid
	// configuration write channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [w2h_pkg::CFG_W-1:0] cfg_data
);
	import w2h_pkg::*;

	localparam int MEM_W = VSUM_W + WSUM_W;

	// input fields
	logic [BIN_W-1:0] bin_x;
	logic [BIN_W-1:0] bin_y;
	logic [VAL_W-1:0] add_value;
	logic [WGT_W-1:0] add_weight;

	// sequencer
	w2h_state_t state_q;
	w2h_state_t state_nxt;
	logic clr_we;
	logic add_we;
	logic div_start;
	logic out_load;
	logic out_free;
	logic [ADDR_W-1:0] clr_addr_q;

	// config registers
	logic [CFG_W-1:0] bins_x_q;
	logic [CFG_W-1:0] bins_y_q;
	logic [CNT_W-1:0] nx;
	logic [CNT_W-1:0] ny;
	logic in_rng;
	logic [ADDR_W-1:0] addr;

	// item registers
	logic [ADDR_W-1:0] addr_q;
	logic [VAL_W-1:0] val_q;
	logic [WGT_W-1:0] wgt_q;
	logic in_range_q;
	logic [VSUM_W-1:0] vsum_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [AVG_W-1:0] avg_q;
	logic avg_valid_q;

	// bin store
	logic [MEM_W-1:0] bin_store_q [STORE_DEPTH];
	logic [MEM_W-1:0] rd_data_q;
	logic [VSUM_W:0] vs_wide;
	logic [WSUM_W:0] ws_wide;
	logic [VSUM_W-1:0] vs_sat;
	logic [WSUM_W-1:0] ws_sat;

	// output register
	logic m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	w2h_div_out_t div_out;

	assign {add_weight, add_value, bin_y, bin_x} = s_tdata;

	// config channel never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_x_q <= CFG_W'(64);
			bins_y_q <= CFG_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BINS_X: bins_x_q <= cfg_data;
				REG_BINS_Y: bins_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bin counts above the grid size act as the grid size
	always_comb begin
		nx = ({2'b0, bins_x_q} > CNT_W'(MAX_BINS_X)) ? CNT_W'(MAX_BINS_X) : {2'b0, bins_x_q};
		ny = ({2'b0, bins_y_q} > CNT_W'(MAX_BINS_Y)) ? CNT_W'(MAX_BINS_Y) : {2'b0, bins_y_q};
		// negative indexes fail on the sign bit
		in_rng = !bin_x[BIN_W-1] && !bin_y[BIN_W-1]
			&& ({1'b0, bin_x} < nx) && ({1'b0, bin_y} < ny);
		// bin (x, y) at x * MAX_BINS_Y + y
		addr = ADDR_W'(32'(bin_x[BIN_W-2:0]) * 32'(MAX_BINS_Y) + 32'(bin_y[BIN_W-2:0]));
	end

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = in_rng ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: state_nxt = ST_ADD;
			ST_ADD: state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = (wsum_q == '0) ? ST_FINISH : ST_DIV;
			ST_DIV: begin
				if (div_out.done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		clr_we = 1'b0;
		add_we = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE: s_tready = 1'b1;
			ST_ADD: add_we = 1'b1;
			ST_CHECK: div_start = (wsum_q != '0);
			ST_FINISH: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (clr_we) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// saturating accumulate of the bin read back from the store
	always_comb begin
		vs_wide = {rd_data_q[MEM_W-1], rd_data_q[MEM_W-1:WSUM_W]}
			+ {{(VSUM_W + 1 - VAL_W){val_q[VAL_W-1]}}, val_q};
		ws_wide = {1'b0, rd_data_q[WSUM_W-1:0]} + {{(WSUM_W + 1 - WGT_W){1'b0}}, wgt_q};
		if (vs_wide[VSUM_W] != vs_wide[VSUM_W-1]) begin
			vs_sat = vs_wide[VSUM_W] ? VSUM_MIN : VSUM_MAX;
		end else begin
			vs_sat = vs_wide[VSUM_W-1:0];
		end
		ws_sat = ws_wide[WSUM_W] ? {WSUM_W{1'b1}} : ws_wide[WSUM_W-1:0];
	end

	// bin store: one write port for the clearing pass or the update write, registered read
	always_ff @(posedge clk) begin
		if (clr_we) begin
			bin_store_q[clr_addr_q] <= '0;
		end else if (add_we) begin
			bin_store_q[addr_q] <= {vs_sat, ws_sat};
		end
		rd_data_q <= bin_store_q[addr_q];
	end

	// item payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_q <= addr;
			val_q <= add_value;
			wgt_q <= add_weight;
			in_range_q <= in_rng;
			if (!in_rng) begin
				// out-of-range result carries all zeros
				vsum_q <= '0;
				wsum_q <= '0;
				avg_q <= '0;
				avg_valid_q <= 1'b0;
			end
		end
		if (add_we) begin
			vsum_q <= vs_sat;
			wsum_q <= ws_sat;
		end
		if (state_q == ST_CHECK && wsum_q == '0) begin
			avg_q <= '0;
			avg_valid_q <= 1'b0;
		end
		if (state_q == ST_DIV && div_out.done) begin
			avg_q <= div_out.quot;
			avg_valid_q <= 1'b1;
		end
	end

	w2h_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.vsum(vsum_q),
		.wsum(wsum_q),
		.div_out(div_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {avg_q, wsum_q, vsum_q};
			m_tuser_q <= {avg_valid_q, in_range_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
